// File: rtl/core/tlsche_pkg.sv
// ----------------------------------------------------------------------------
// tlsche_pkg: shared types and constants for the ClientHello field extractor
// Request/response payload structs, item kinds and front-to-back record.
// ----------------------------------------------------------------------------
package tlsche_pkg;

   localparam int DefaultMaxVersions = 32;

   localparam logic [2:0] KIND_RANDOM  = 3'd0;
   localparam logic [2:0] KIND_SESSION = 3'd1;
   localparam logic [2:0] KIND_NAME    = 3'd2;
   localparam logic [2:0] KIND_KEY     = 3'd3;
   localparam logic [2:0] KIND_VERSION = 3'd4;
   localparam logic [2:0] KIND_STATUS  = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [15:0] item_value;
      logic        parse_ok;
      logic        name_found;
      logic        key_found;
      logic [5:0]  version_count;
      logic        last_of_run;
   } rsp_type;

   // One classified byte: up to two result items.
   typedef struct packed {
      logic    has_first;
      logic    has_second;
      rsp_type first;
      rsp_type second;
   } work_type;

endpackage

// File: rtl/core/tlsche_front.sv
// ----------------------------------------------------------------------------
// tlsche_front: byte parser
// Walks the record, handshake header and extension block one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module tlsche_front #(
   parameter int MAX_VERSIONS = tlsche_pkg::DefaultMaxVersions
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tlsche_pkg::req_type  req,
   output tlsche_pkg::work_type work
);
   import tlsche_pkg::*;

   localparam int VCapInt = (MAX_VERSIONS > 63) ? 63 : MAX_VERSIONS;
   localparam logic [5:0] VCap = 6'(VCapInt);
   localparam logic [25:0] PosCap = 26'h2000000;

   localparam logic [4:0] PH_HEAD = 5'd0, PH_SID = 5'd1, PH_CS_HI = 5'd2,
      PH_CS_LO = 5'd3, PH_CS = 5'd4, PH_COMP_LEN = 5'd5, PH_COMP = 5'd6,
      PH_EXT_HI = 5'd7, PH_EXT_LO = 5'd8, PH_XH0 = 5'd9, PH_XH1 = 5'd10,
      PH_XH2 = 5'd11, PH_XH3 = 5'd12, PH_IDLE = 5'd13, PH_XSKIP = 5'd14,
      PH_S_SKIP = 5'd15, PH_S_TYPE = 5'd16, PH_S_NHI = 5'd17, PH_S_NLO = 5'd18,
      PH_S_NAME = 5'd19, PH_K_L0 = 5'd20, PH_K_L1 = 5'd21, PH_K_G0 = 5'd22,
      PH_K_G1 = 5'd23, PH_K_N0 = 5'd24, PH_K_N1 = 5'd25, PH_K_SKIP = 5'd26,
      PH_K_PRE = 5'd27, PH_K_KEY = 5'd28, PH_V_LEN = 5'd29, PH_V_HI = 5'd30,
      PH_V_LO = 5'd31;

   logic [4:0]  phase_ff, phase_in;
   logic [25:0] pos_ff, pos_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic [23:0] hs_len_ff, hs_len_in;
   logic [15:0] remain_ff, remain_in;
   logic [17:0] exts_end_ff, exts_end_in, ext_end_ff, ext_end_in;
   logic [17:0] list_end_ff, list_end_in;
   logic [15:0] ext_id_ff, ext_id_in, group_ff, group_in;
   logic [7:0]  held_ff, held_in;
   logic [3:0]  flags_ff, flags_in;
   logic        err_ff, err_in;
   logic [5:0]  vseen_ff, vseen_in;
   logic [7:0]  vpend_ff, vpend_in;

   logic [7:0]  b;
   logic [15:0] w;
   logic [26:0] p1;
   logic        emit;
   logic [2:0]  ekind;
   logic [15:0] evalue;
   logic [26:0] wend;
   logic [7:0]  vsum;
   logic [26:0] sz;
   logic        ok;
   rsp_type     r1, r2;

   always_comb begin
      b = req.data_byte;
      w = {held_ff, b};
      p1 = {1'b0, pos_ff} + 27'd1;
      phase_in = phase_ff; pos_in = pos_ff; rec_len_in = rec_len_ff;
      hs_len_in = hs_len_ff; remain_in = remain_ff; exts_end_in = exts_end_ff;
      ext_end_in = ext_end_ff; list_end_in = list_end_ff; ext_id_in = ext_id_ff;
      group_in = group_ff; held_in = held_ff; flags_in = flags_ff; err_in = err_ff;
      vseen_in = vseen_ff; vpend_in = vpend_ff;
      emit = 1'b0; ekind = KIND_RANDOM; evalue = {8'd0, b};
      wend = p1 + 27'(w);
      case (phase_ff)
         PH_HEAD: begin
            if (pos_ff == 26'd0 && b != 8'd22) begin
               err_in = 1'b1; phase_in = PH_IDLE;
            end else if (pos_ff == 26'd3) held_in = b;
            else if (pos_ff == 26'd4) rec_len_in = w;
            else if (pos_ff == 26'd5 && b != 8'd1) begin
               err_in = 1'b1; phase_in = PH_IDLE;
            end else if (pos_ff >= 26'd6 && pos_ff <= 26'd8)
               hs_len_in = {hs_len_ff[15:0], b};
            else if (pos_ff >= 26'd11 && pos_ff <= 26'd42) begin
               emit = 1'b1; ekind = KIND_RANDOM;
            end else if (pos_ff >= 26'd43) begin
               if (b > 8'd32) begin
                  err_in = 1'b1; phase_in = PH_IDLE;
               end else if (b == 8'd0) phase_in = PH_CS_HI;
               else begin
                  remain_in = {8'd0, b}; phase_in = PH_SID;
               end
            end
         end
         PH_SID: begin
            emit = 1'b1; ekind = KIND_SESSION;
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_CS_HI;
         end
         PH_CS_HI: begin held_in = b; phase_in = PH_CS_LO; end
         PH_CS_LO: begin
            if (w[0]) begin
               err_in = 1'b1; phase_in = PH_IDLE;
            end else if (w == 16'd0) phase_in = PH_COMP_LEN;
            else begin
               remain_in = w; phase_in = PH_CS;
            end
         end
         PH_CS: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_COMP_LEN;
         end
         PH_COMP_LEN: begin
            if (b == 8'd0) phase_in = PH_EXT_HI;
            else begin
               remain_in = {8'd0, b}; phase_in = PH_COMP;
            end
         end
         PH_COMP: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_EXT_HI;
         end
         PH_EXT_HI: begin held_in = b; phase_in = PH_EXT_LO; end
         PH_EXT_LO: begin
            // positions stay below 2^17 here, so 18 bits hold the end
            exts_end_in = wend[17:0]; phase_in = PH_XH0;
         end
         PH_XH0: begin
            if ({1'b0, pos_ff} + 27'd4 > {9'd0, exts_end_ff}) phase_in = PH_IDLE;
            else begin
               held_in = b; phase_in = PH_XH1;
            end
         end
         PH_XH1: begin ext_id_in = w; phase_in = PH_XH2; end
         PH_XH2: begin held_in = b; phase_in = PH_XH3; end
         PH_XH3: begin
            ext_end_in = wend[17:0];
            flags_in = {2'b00, flags_ff[1:0]};
            vpend_in = 8'd0;
            if (w == 16'd0) phase_in = PH_XH0;
            else if (ext_id_ff == 16'd0) begin
               remain_in = 16'd2; phase_in = PH_S_SKIP;
            end else if (ext_id_ff == 16'd51) phase_in = PH_K_L0;
            else if (ext_id_ff == 16'd43) phase_in = PH_V_LEN;
            else phase_in = PH_XSKIP;
         end
         PH_S_SKIP: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_S_TYPE;
         end
         PH_S_TYPE: begin
            if ({1'b0, pos_ff} + 27'd3 > {9'd0, ext_end_ff}) phase_in = PH_XSKIP;
            else begin
               group_in = {8'd0, b}; phase_in = PH_S_NHI;
            end
         end
         PH_S_NHI: begin held_in = b; phase_in = PH_S_NLO; end
         PH_S_NLO: begin
            if (group_ff != 16'd0) begin
               if (w == 16'd0) phase_in = PH_S_TYPE;
               else begin
                  remain_in = w; phase_in = PH_S_SKIP;
               end
            end else if (wend > {9'd0, ext_end_ff}) phase_in = PH_XSKIP;
            else begin
               flags_in[2] = 1'b1;
               if (w == 16'd0) phase_in = PH_XSKIP;
               else begin
                  remain_in = w; phase_in = PH_S_NAME;
               end
            end
         end
         PH_S_NAME: begin
            emit = 1'b1; ekind = KIND_NAME;
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_XSKIP;
         end
         PH_K_L0: begin held_in = b; phase_in = PH_K_L1; end
         PH_K_L1: begin
            list_end_in = (wend < {9'd0, ext_end_ff}) ? wend[17:0] : ext_end_ff;
            phase_in = PH_K_G0;
         end
         PH_K_G0: begin
            if ({1'b0, pos_ff} + 27'd4 > {9'd0, list_end_ff}) phase_in = PH_XSKIP;
            else begin
               held_in = b; phase_in = PH_K_G1;
            end
         end
         PH_K_G1: begin group_in = w; phase_in = PH_K_N0; end
         PH_K_N0: begin held_in = b; phase_in = PH_K_N1; end
         PH_K_N1: begin
            if (wend > {9'd0, list_end_ff}) phase_in = PH_XSKIP;
            else if (group_ff == 16'h001d && w == 16'd32) begin
               flags_in[3] = 1'b1; remain_in = 16'd32; phase_in = PH_K_KEY;
            end else if (group_ff == 16'h11ec && w >= 16'd32) begin
               flags_in[3] = 1'b1;
               if (w > 16'd32) begin
                  remain_in = w - 16'd32; phase_in = PH_K_PRE;
               end else begin
                  remain_in = 16'd32; phase_in = PH_K_KEY;
               end
            end else if (w == 16'd0) phase_in = PH_K_G0;
            else begin
               remain_in = w; phase_in = PH_K_SKIP;
            end
         end
         PH_K_SKIP: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_K_G0;
         end
         PH_K_PRE: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) begin
               remain_in = 16'd32; phase_in = PH_K_KEY;
            end
         end
         PH_K_KEY: begin
            emit = 1'b1; ekind = KIND_KEY;
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) phase_in = PH_XSKIP;
         end
         PH_V_LEN: begin
            wend = p1 + 27'(b);
            list_end_in = (wend < {9'd0, ext_end_ff}) ? wend[17:0] : ext_end_ff;
            phase_in = PH_V_HI;
         end
         PH_V_HI: begin
            if ({1'b0, pos_ff} + 27'd2 > {9'd0, list_end_ff}) phase_in = PH_XSKIP;
            else begin
               held_in = b; phase_in = PH_V_HI + 5'd1;
            end
         end
         PH_V_LO: begin
            emit = 1'b1; ekind = KIND_VERSION; evalue = w;
            if (vpend_ff != 8'd255) vpend_in = vpend_ff + 8'd1;
            phase_in = PH_V_HI;
         end
         default: ;
      endcase

      // close the current extension on its last byte
      vsum = 8'd0;
      if (phase_in >= PH_XSKIP && p1 >= {9'd0, ext_end_in}) begin
         flags_in = {2'b00, flags_in[1:0] | flags_in[3:2]};
         vsum = 8'(vseen_ff) + vpend_in;
         vseen_in = ({1'b0, vsum} < {3'd0, VCap}) ? vsum[5:0] : VCap;
         vpend_in = 8'd0;
         phase_in = PH_XH0;
      end

      if (pos_ff < PosCap) pos_in = p1[25:0];
      sz = {1'b0, pos_in};
      ok = !err_ff && !err_in && phase_in >= PH_EXT_HI
           && sz >= 27'd5 + 27'(rec_len_in) && sz >= 27'd9 + 27'(hs_len_in);

      r1 = '0;
      r1.item_kind = ekind; r1.item_value = evalue;
      r2 = '0;
      r2.item_kind = KIND_STATUS;
      r2.last_of_run = 1'b1;
      if (ok) begin
         r2.parse_ok = 1'b1; r2.name_found = flags_in[0];
         r2.key_found = flags_in[1]; r2.version_count = vseen_in;
      end
      work = '0;
      if (emit) begin
         work.has_first = 1'b1;
         work.first = r1;
         work.first.last_of_run = !req.end_of_buffer;
         if (req.end_of_buffer) begin
            work.has_second = 1'b1; work.second = r2;
         end
      end else if (req.end_of_buffer) begin
         work.has_first = 1'b1; work.first = r2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.end_of_buffer)) begin
         phase_ff <= PH_HEAD; pos_ff <= '0; rec_len_ff <= '0; hs_len_ff <= '0;
         remain_ff <= '0; exts_end_ff <= '0; ext_end_ff <= '0; list_end_ff <= '0;
         ext_id_ff <= '0; group_ff <= '0; held_ff <= '0; flags_ff <= '0;
         err_ff <= 1'b0; vseen_ff <= '0; vpend_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; rec_len_ff <= rec_len_in;
         hs_len_ff <= hs_len_in; remain_ff <= remain_in; exts_end_ff <= exts_end_in;
         ext_end_ff <= ext_end_in; list_end_ff <= list_end_in;
         ext_id_ff <= ext_id_in; group_ff <= group_in; held_ff <= held_in;
         flags_ff <= flags_in; err_ff <= err_in; vseen_ff <= vseen_in;
         vpend_ff <= vpend_in;
      end
   end

endmodule

// File: rtl/core/tlsche_queue.sv
// ----------------------------------------------------------------------------
// tlsche_queue: result queue
// Takes up to two results a cycle, hands out one a cycle when popped, oldest first.
// ----------------------------------------------------------------------------
module tlsche_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 write,
   input  tlsche_pkg::work_type work,
   input  logic                 pop,
   output logic                 empty,
   output logic                 room,
   output tlsche_pkg::rsp_type  head
);
   import tlsche_pkg::*;

   localparam int Depth = 8;

   rsp_type    mem_ff [Depth];
   logic [2:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] nwr;
   logic       rd;

   assign empty = (count_ff == 4'd0);
   // room for a full pair even when nothing is drained this cycle
   assign room  = (count_ff <= 4'(Depth - 2));
   assign head  = mem_ff[rptr_ff];
   assign rd    = pop && !empty;

   always_comb begin
      nwr = 4'd0;
      if (write) nwr = 4'(work.has_first) + 4'(work.has_second);
      wptr_in  = wptr_ff + nwr[2:0];
      rptr_in  = rptr_ff + 3'(rd);
      count_in = count_ff + nwr - 4'(rd);
   end

   always_ff @(posedge clock) begin
      if (write && work.has_first) mem_ff[wptr_ff] <= work.first;
      if (write && work.has_second) mem_ff[wptr_ff + 3'd1] <= work.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0; rptr_ff <= '0; count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in; rptr_ff <= rptr_in; count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/tls_client_hello_field_extractor.sv
// ----------------------------------------------------------------------------
// tls_client_hello_field_extractor: ClientHello field extractor
// Parses a TLS record byte stream and emits tagged ClientHello fields.
// ----------------------------------------------------------------------------
//  channel   | ports                          | moves
//  request   | req_push, req_full, req_data   | one record byte per transaction
//  response  | rsp_pop, rsp_empty, rsp_data   | one tagged item per transaction
//
// One byte is taken every cycle while req_full is low; the parser updates in
// that same cycle and drops zero, one or two items into an 8-entry queue.
// A result is registered in the queue and appears on rsp_data once older results have been popped.
// req_full rises when the queue has fewer than two free entries, so a stall
// on the response side holds the request side only once the queue fills.
// Reset is synchronous and clears the parser and queue pointers.
module tls_client_hello_field_extractor #(
   parameter int MAX_VERSIONS = tlsche_pkg::DefaultMaxVersions
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  tlsche_pkg::req_type req_data,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output tlsche_pkg::rsp_type rsp_data
);
   import tlsche_pkg::*;

   logic     step;
   logic     room;
   work_type work;

   // accept a transaction whenever the queue can take a full pair
   assign req_full = !room;
   assign step     = req_push && room;

   tlsche_front #(.MAX_VERSIONS(MAX_VERSIONS)) u_front (
      .clock(clock), .reset(reset), .step(step), .req(req_data), .work(work)
   );

   tlsche_queue u_queue (
      .clock(clock), .reset(reset), .write(step), .work(work),
      .pop(rsp_pop), .empty(rsp_empty), .room(room), .head(rsp_data)
   );

   // a status item always ends its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.item_kind == KIND_STATUS |-> rsp_data.last_of_run)
      else $error("status item without last_of_run");

   // the end-of-buffer byte always yields a result
   a_eob_result: assert property (@(posedge clock) disable iff (reset)
      step && req_data.end_of_buffer |=> !rsp_empty)
      else $error("final byte produced no result");

   // status fields are zero unless the parse succeeded
   a_flags_ok: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.parse_ok |->
      !rsp_data.name_found && !rsp_data.key_found && rsp_data.version_count == 6'd0)
      else $error("flags set on failed parse");

endmodule
